>>> hw/rtl/hdlc_frame_builder_fcs16_macros.svh
// assertion macros for the hdlc frame builder checker
// no dependencies; included by the checker file only
`ifndef HDLC_FRAME_BUILDER_FCS16_MACROS_SVH
`define HDLC_FRAME_BUILDER_FCS16_MACROS_SVH

// same-cycle implication under clock and active-low reset
`define HFB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hfb assertion failed");

// next-cycle implication under clock and active-low reset
`define HFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hfb assertion failed");

`endif

>>> hw/rtl/hfb_pkg.sv
// shared types, constants and the crc fold for the hdlc frame builder
// no dependencies
`default_nettype none

package hfb_pkg;

    localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam int          QUEUE_DEPTH = 4;

    localparam logic [1:0] KIND_CONTENT = 2'd0;
    localparam logic [1:0] KIND_FLAG    = 2'd1;
    localparam logic [1:0] KIND_FCS     = 2'd2;

    // one classified content byte waiting for the back end
    typedef struct packed {
        logic [7:0]  content_byte;
        logic        open;
        logic        last;
        logic [15:0] fcs;
    } t_entry;

    // reflected crc-16, one byte, lsb first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hfb_if.sv
// valid/ready channel interfaces for content bytes in and line bytes out
// no dependencies
`default_nettype none

interface hfb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] content_byte;
    logic       frame_end;

    modport source (output valid, output content_byte, output frame_end, input ready);
    modport sink   (input valid, input content_byte, input frame_end, output ready);
endinterface

interface hfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic       run_last;

    modport source (output valid, output out_byte, output byte_kind, output run_last,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_kind, input run_last,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hfb_front.sv
// front end: accepts content beats, tracks frame state, folds the crc
// depends on hfb_pkg and hfb_in_if
`default_nettype none

module hfb_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    hfb_in_if.sink             i_in,
    input  wire logic          i_full,
    output logic               o_push,
    output hfb_pkg::t_entry    o_entry
);
    import hfb_pkg::*;

    logic [15:0] r_crc, n_crc;
    logic        r_in_frame, n_in_frame;
    logic [15:0] crc_base;
    logic [15:0] crc_new;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        crc_base = r_in_frame ? r_crc : CRC_INIT;
        crc_new  = crc_fold(crc_base, i_in.content_byte);

        o_entry.content_byte = i_in.content_byte;
        o_entry.open         = !r_in_frame;
        o_entry.last         = i_in.frame_end;
        o_entry.fcs          = ~crc_new;

        n_crc      = r_crc;
        n_in_frame = r_in_frame;
        if (o_push) begin
            n_crc      = i_in.frame_end ? CRC_INIT : crc_new;
            n_in_frame = !i_in.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= CRC_INIT;
            r_in_frame <= 1'b0;
        end else begin
            r_crc      <= n_crc;
            r_in_frame <= n_in_frame;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/hfb_queue.sv
// short fifo of classified entries between front and back ends
// depends on hfb_pkg
`default_nettype none

module hfb_queue #(
    parameter int DEPTH = hfb_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire hfb_pkg::t_entry  i_entry,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output hfb_pkg::t_entry       o_head
);
    import hfb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/hfb_back.sv
// back end: expands entries into beats: flag at frame open, one content beat each, fcs and flag at frame end
// depends on hfb_pkg and hfb_out_if
`default_nettype none

module hfb_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  wire hfb_pkg::t_entry  i_head,
    output logic                  o_pop,
    hfb_out_if.source             o_out
);
    import hfb_pkg::*;

    typedef enum logic [4:0] {
        PH_HEAD   = 5'b00001,
        PH_BODY   = 5'b00010,
        PH_FCS_LO = 5'b00100,
        PH_FCS_HI = 5'b01000,
        PH_TAIL   = 5'b10000
    } t_phase;

    t_phase     r_phase, n_phase;
    t_phase     cur, nxt;
    logic       r_valid, n_valid;
    logic [7:0] r_byte, n_byte;
    logic [1:0] r_kind, n_kind;
    logic       r_last, n_last;
    logic       adv, take;
    logic [7:0] beat_byte;
    logic [1:0] beat_kind;
    logic       beat_last;

    assign adv  = !r_valid || o_out.ready;
    assign take = adv && !i_empty;

    always_comb begin
        cur = (r_phase == PH_HEAD && !i_head.open) ? PH_BODY : r_phase;
        beat_byte = i_head.content_byte;
        beat_kind = KIND_CONTENT;
        beat_last = 1'b0;
        nxt       = PH_HEAD;
        case (cur)
            PH_HEAD: begin
                beat_byte = FLAG_BYTE;
                beat_kind = KIND_FLAG;
                nxt       = PH_BODY;
            end
            PH_BODY: begin
                beat_byte = i_head.content_byte;
                beat_kind = KIND_CONTENT;
                beat_last = !i_head.last;
                nxt       = PH_FCS_LO;
            end
            PH_FCS_LO: begin
                beat_byte = i_head.fcs[7:0];
                beat_kind = KIND_FCS;
                nxt       = PH_FCS_HI;
            end
            PH_FCS_HI: begin
                beat_byte = i_head.fcs[15:8];
                beat_kind = KIND_FCS;
                nxt       = PH_TAIL;
            end
            PH_TAIL: begin
                beat_byte = FLAG_BYTE;
                beat_kind = KIND_FLAG;
                beat_last = 1'b1;
                nxt       = PH_HEAD;
            end
            default: begin
                beat_byte = FLAG_BYTE;
                beat_kind = KIND_FLAG;
                beat_last = 1'b1;
                nxt       = PH_HEAD;
            end
        endcase
    end

    assign o_pop = take && beat_last;

    always_comb begin
        n_phase = r_phase;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_kind  = r_kind;
        n_last  = r_last;
        if (adv) begin
            n_valid = !i_empty;
        end
        if (take) begin
            n_phase = beat_last ? PH_HEAD : nxt;
            n_byte  = beat_byte;
            n_kind  = beat_kind;
            n_last  = beat_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_kind <= n_kind;
        r_last <= n_last;
    end

    assign o_out.valid     = r_valid;
    assign o_out.out_byte  = r_byte;
    assign o_out.byte_kind = r_kind;
    assign o_out.run_last  = r_last;

endmodule

`default_nettype wire

>>> hw/rtl/hdlc_frame_builder_fcs16.sv
// HDLC-style frame builder with CRC-16/X.25 FCS. Content beats (address,
// control, payload; frame_end on the last) enter one per cycle while the
// QUEUE_DEPTH-entry queue has room. Each line beat leaves through a
// registered output at one beat per cycle while the sink is ready and
// the queue holds an entry: a content byte inside a frame gives one beat,
// the opening flag adds one, and the FCS low, FCS high and closing flag
// add three, so a frame of N content bytes gives N + 4 line beats.
// No bit stuffing and no frame length limit. Depends on hfb_pkg, hfb_if,
// hfb_front, hfb_queue and hfb_back.
`default_nettype none

module hdlc_frame_builder_fcs16 #(
    parameter int QUEUE_DEPTH = hfb_pkg::QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hfb_in_if.sink    i_in,
    hfb_out_if.source o_out
);
    import hfb_pkg::*;

    logic   q_push, q_pop, q_full, q_empty;
    t_entry q_in_entry, q_head;

    hfb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_entry (q_in_entry)
    );

    hfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    hfb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

>>> hw/rtl/hfb_checker.sv
// port-level checks on the frame builder output stream, bound to the top
// depends on hfb_pkg and hdlc_frame_builder_fcs16_macros.svh
`default_nettype none
`include "hdlc_frame_builder_fcs16_macros.svh"

module hfb_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic [1:0] i_out_kind,
    input wire logic       i_out_last
);
    import hfb_pkg::*;

    logic out_hold;
    logic out_flag;
    logic out_fcs;
    logic in_idle;

    assign out_hold = i_out_valid && !i_out_ready;
    assign out_flag = i_out_valid && (i_out_kind == KIND_FLAG);
    assign out_fcs  = i_out_valid && (i_out_kind == KIND_FCS);
    assign in_idle  = !(i_in_valid && i_in_ready);

    // every flag beat carries the flag pattern
    `HFB_ASSERT_SAME(a_flag_byte, i_clk, i_rst_n, out_flag, i_out_byte == FLAG_BYTE)
    // fcs beats are never the end of a run
    `HFB_ASSERT_SAME(a_fcs_not_last, i_clk, i_rst_n, out_fcs, !i_out_last)
    // a stalled output beat holds its payload
    `HFB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_hold,
        i_out_valid && $stable(i_out_byte) && $stable(i_out_kind) && $stable(i_out_last))
    // an accepted fcs beat is followed at once by the next beat of its frame
    `HFB_ASSERT_NEXT(a_fcs_then_more, i_clk, i_rst_n, out_fcs && i_out_ready && in_idle,
        i_out_valid)

endmodule

bind hdlc_frame_builder_fcs16 hfb_checker u_hfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_kind  (o_out.byte_kind),
    .i_out_last  (o_out.run_last)
);

`default_nettype wire
